// ----- design/mexp_pkg.sv -----
`timescale 1ns / 1ps
package mexp_pkg;

   localparam int WIDTH = 32;
   localparam int CNT_W = $clog2(WIDTH);
   localparam int PC_W  = 4;
   localparam logic [WIDTH-1:0] MODULUS_RESET = WIDTH'(64'd1000000007);

   localparam logic OPC_POWER   = 1'b0;
   localparam logic OPC_INVERSE = 1'b1;

   // Datapath actions, one per control word.
   typedef enum logic [3:0] {
      ACT_NOP,
      ACT_LOAD,
      ACT_RED_INIT,
      ACT_RED_STEP,
      ACT_RED_STORE,
      ACT_MULA_INIT,
      ACT_MUL_STEP,
      ACT_STORE_ACC,
      ACT_MULB_INIT,
      ACT_STORE_B,
      ACT_EMIT
   } act_type;

   // Jump conditions; the jump is taken when the condition holds.
   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_SPECIAL,
      COND_M_ZERO,
      COND_NOT_LAST,
      COND_E0_ZERO,
      COND_E_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      act_type           act;
      cond_type          cond;
      logic [PC_W-1:0]   target;
   } uword_type;

   typedef struct packed {
      logic req_fire;
      logic special;
      logic m_zero;
      logic not_last;
      logic e0_zero;
      logic e_more;
      logic out_busy;
   } status_type;

   // Program addresses.
   localparam logic [PC_W-1:0] PC_WAIT      = PC_W'(0);
   localparam logic [PC_W-1:0] PC_CHECK     = PC_W'(1);
   localparam logic [PC_W-1:0] PC_RED_INIT  = PC_W'(2);
   localparam logic [PC_W-1:0] PC_RED_STEP  = PC_W'(3);
   localparam logic [PC_W-1:0] PC_RED_STORE = PC_W'(4);
   localparam logic [PC_W-1:0] PC_MULA_INIT = PC_W'(5);
   localparam logic [PC_W-1:0] PC_MULA_STEP = PC_W'(6);
   localparam logic [PC_W-1:0] PC_STORE_ACC = PC_W'(7);
   localparam logic [PC_W-1:0] PC_MULB_INIT = PC_W'(8);
   localparam logic [PC_W-1:0] PC_MULB_STEP = PC_W'(9);
   localparam logic [PC_W-1:0] PC_STORE_B   = PC_W'(10);
   localparam logic [PC_W-1:0] PC_EMIT      = PC_W'(11);
   localparam logic [PC_W-1:0] PC_RETURN    = PC_W'(12);

   function automatic uword_type ucode_rom(logic [PC_W-1:0] pc);
      uword_type w;
      case (pc)
         PC_WAIT:      w = '{ACT_LOAD,      COND_NO_REQ,   PC_WAIT};
         PC_CHECK:     w = '{ACT_NOP,       COND_SPECIAL,  PC_EMIT};
         PC_RED_INIT:  w = '{ACT_RED_INIT,  COND_M_ZERO,   PC_MULA_INIT};
         PC_RED_STEP:  w = '{ACT_RED_STEP,  COND_NOT_LAST, PC_RED_STEP};
         PC_RED_STORE: w = '{ACT_RED_STORE, COND_NEVER,    PC_WAIT};
         PC_MULA_INIT: w = '{ACT_MULA_INIT, COND_E0_ZERO,  PC_MULB_INIT};
         PC_MULA_STEP: w = '{ACT_MUL_STEP,  COND_NOT_LAST, PC_MULA_STEP};
         PC_STORE_ACC: w = '{ACT_STORE_ACC, COND_NEVER,    PC_WAIT};
         PC_MULB_INIT: w = '{ACT_MULB_INIT, COND_NEVER,    PC_WAIT};
         PC_MULB_STEP: w = '{ACT_MUL_STEP,  COND_NOT_LAST, PC_MULB_STEP};
         PC_STORE_B:   w = '{ACT_STORE_B,   COND_E_MORE,   PC_MULA_INIT};
         PC_EMIT:      w = '{ACT_EMIT,      COND_OUT_BUSY, PC_EMIT};
         PC_RETURN:    w = '{ACT_NOP,       COND_ALWAYS,   PC_WAIT};
         default:      w = '{ACT_NOP,       COND_ALWAYS,   PC_WAIT};
      endcase
      return w;
   endfunction

   // One step of the shift-add-subtract reducer: (2*p + addend) mod m.
   // Requires p < m and addend < m, so at most two subtractions of m are needed.
   // A modulus of zero stands for 2^WIDTH and simply wraps.
   function automatic logic [WIDTH-1:0] mod_step(logic [WIDTH-1:0] p,
                                                 logic [WIDTH-1:0] addend,
                                                 logic [WIDTH-1:0] m);
      logic [WIDTH+1:0] t;
      logic [WIDTH+2:0] d1;
      logic [WIDTH+2:0] d2;
      t  = {1'b0, p, 1'b0} + {2'b00, addend};
      d1 = {1'b0, t} - {3'b000, m};
      d2 = {1'b0, t} - {2'b00, m, 1'b0};
      if (m == '0) begin
         return t[WIDTH-1:0];
      end else if (!d2[WIDTH+2]) begin
         return d2[WIDTH-1:0];
      end else if (!d1[WIDTH+2]) begin
         return d1[WIDTH-1:0];
      end
      return t[WIDTH-1:0];
   endfunction

endpackage

// ----- design/mexp_sequencer.sv -----
`timescale 1ns / 1ps
module mexp_sequencer import mexp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output act_type    act
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   uword_type       word;
   logic            take;

   assign word = ucode_rom(pc_ff);
   assign act  = word.act;

   always_comb begin
      case (word.cond)
         COND_NEVER:    take = 1'b0;
         COND_ALWAYS:   take = 1'b1;
         COND_NO_REQ:   take = !status.req_fire;
         COND_SPECIAL:  take = status.special;
         COND_M_ZERO:   take = status.m_zero;
         COND_NOT_LAST: take = status.not_last;
         COND_E0_ZERO:  take = status.e0_zero;
         COND_E_MORE:   take = status.e_more;
         COND_OUT_BUSY: take = status.out_busy;
         default:       take = 1'b1;
      endcase
   end

   always_comb begin
      if (take) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ----- design/mexp_datapath.sv -----
`timescale 1ns / 1ps
module mexp_datapath import mexp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  act_type          act,
   output status_type       status,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [2*WIDTH-1:0] req_tdata,
   input  logic             req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [WIDTH-1:0] rsp_tdata,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [WIDTH-1:0] csr_data
);

   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] e_ff, e_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] y_ff, y_in;
   logic [WIDTH-1:0] p_ff, p_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             special_ff, special_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic [WIDTH-1:0] in_base;
   logic [WIDTH-1:0] in_exp;
   logic             in_special;
   logic             req_fire;
   logic             out_busy;
   logic [WIDTH-1:0] addend;

   assign in_base    = req_tdata[WIDTH-1:0];
   assign in_exp     = req_tdata[2*WIDTH-1:WIDTH];
   // A waiting modulus write goes first, so an item never sees the modulus change.
   assign req_tready = (act == ACT_LOAD) && !csr_valid;
   // The modulus may only change while no item is in progress.
   assign csr_ready  = (act == ACT_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign out_busy   = rsp_valid_ff && !rsp_tready;

   assign in_special = (req_tuser == OPC_INVERSE) ? (m_ff < WIDTH'(3)) : (in_exp == '0);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.req_fire = req_fire;
   assign status.special  = special_ff;
   assign status.m_zero   = (m_ff == '0);
   assign status.not_last = (cnt_ff != '0);
   assign status.e0_zero  = !e_ff[0];
   assign status.e_more   = (e_ff[WIDTH-1:1] != '0);
   assign status.out_busy = out_busy;

   always_comb begin
      if (act == ACT_RED_STEP) begin
         addend = {{(WIDTH-1){1'b0}}, y_ff[WIDTH-1]};
      end else if (y_ff[WIDTH-1]) begin
         addend = x_ff;
      end else begin
         addend = '0;
      end
   end

   always_comb begin
      m_in         = m_ff;
      acc_in       = acc_ff;
      b_in         = b_ff;
      e_in         = e_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      p_in         = p_ff;
      cnt_in       = cnt_ff;
      special_in   = special_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (csr_valid && csr_ready) begin
         m_in = csr_data;
      end
      case (act)
         ACT_LOAD: begin
            if (req_fire) begin
               b_in       = in_base;
               e_in       = (req_tuser == OPC_INVERSE) ? (m_ff - WIDTH'(2)) : in_exp;
               special_in = in_special;
               // The starting one is reduced only for a modulus of one.
               acc_in     = (!in_special && m_ff == WIDTH'(1)) ? '0 : WIDTH'(1);
            end
         end
         ACT_RED_INIT: begin
            p_in   = '0;
            y_in   = b_ff;
            cnt_in = CNT_W'(WIDTH - 1);
         end
         ACT_RED_STEP, ACT_MUL_STEP: begin
            p_in   = mod_step(p_ff, addend, m_ff);
            y_in   = {y_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         ACT_RED_STORE: begin
            b_in = p_ff;
         end
         ACT_MULA_INIT: begin
            p_in   = '0;
            x_in   = b_ff;
            y_in   = acc_ff;
            cnt_in = CNT_W'(WIDTH - 1);
         end
         ACT_STORE_ACC: begin
            acc_in = p_ff;
         end
         ACT_MULB_INIT: begin
            p_in   = '0;
            x_in   = b_ff;
            y_in   = b_ff;
            cnt_in = CNT_W'(WIDTH - 1);
         end
         ACT_STORE_B: begin
            b_in = p_ff;
            e_in = {1'b0, e_ff[WIDTH-1:1]};
         end
         ACT_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff         <= MODULUS_RESET;
         rsp_valid_ff <= 1'b0;
         special_ff   <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         m_ff         <= m_in;
         rsp_valid_ff <= rsp_valid_in;
         special_ff   <= special_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      b_ff        <= b_in;
      e_ff        <= e_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      p_ff        <= p_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The partial product and the multiplicand stay reduced through a multiply.
   a_mul_reduced: assert property (@(posedge clock) disable iff (reset)
      (act == ACT_MUL_STEP && m_ff != '0) |-> (p_ff < m_ff && x_ff < m_ff))
      else $error("modular multiply operand not reduced");

   // A new result is only raised by the emit step.
   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(act == ACT_EMIT))
      else $error("result raised outside the emit step");

   // Products are stored only after a full multiply loop.
   a_store_after_loop: assert property (@(posedge clock) disable iff (reset)
      (act == ACT_STORE_ACC || act == ACT_STORE_B) |->
         ($past(act == ACT_MUL_STEP) && $past(cnt_ff) == '0))
      else $error("product stored before the multiply loop finished");

   // A special-case item reaches the emit step holding one.
   a_special_one: assert property (@(posedge clock) disable iff (reset)
      (act == ACT_EMIT && special_ff) |-> (acc_ff == WIDTH'(1)))
      else $error("special case result is not one");

endmodule

// ----- design/modular_exponentiation.sv -----
`timescale 1ns / 1ps
// Computes base^exponent mod modulus by right-to-left square-and-multiply under a
// small microcode program. Opcode 1 returns the inverse of base by raising it to
// modulus-2. The modulus register (reset 1000000007) is written through the csr
// channel, which is ready only while no item is in progress, and a pending csr write
// is taken ahead of a waiting item; a modulus of zero means 2^32. A zero exponent,
// or an inverse with a modulus below three, returns 1 without any multiply.
// Otherwise an item first reduces the base, then, for each exponent bit up to the
// highest set bit, multiplies the accumulator by the base when that bit is set and
// squares the base, and then emits the result. Each multiply runs on the bit-serial
// modular multiplier, which retires one multiplier bit per cycle. One item is in
// work at a time, and the next item is taken while the previous result waits in
// the output register.
module modular_exponentiation import mexp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [2*WIDTH-1:0]   req_tdata,   // base [31:0], exponent [63:32]
   input  logic                 req_tuser,   // opcode [0]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [WIDTH-1:0]     rsp_tdata,   // result [31:0]
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [WIDTH-1:0]     csr_data
);

   act_type    act;
   status_type status;

   mexp_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .act    (act)
   );

   mexp_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .act        (act),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
module tb import mexp_pkg::*; ();

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int RANDOM_PER_PHASE = 30;
   localparam int NUM_PHASES = 8;

   typedef struct packed {
      logic             opcode;
      logic [WIDTH-1:0] base;
      logic [WIDTH-1:0] exponent;
   } power_request_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [2*WIDTH-1:0] req_tdata = '0;   // base [31:0], exponent [63:32]
   logic               req_tuser = 1'b0; // opcode [0]
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [WIDTH-1:0]   rsp_tdata;        // result [31:0]
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [WIDTH-1:0]   csr_data = '0;

   power_request_type  pending_requests[$];
   logic [WIDTH-1:0]   expected_results[$];
   logic [WIDTH-1:0]   modulus_now = MODULUS_RESET;
   logic [WIDTH-1:0]   wanted_result;
   power_request_type  next_request;
   logic               req_fired = 1'b0;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   int                 error_count = 0;
   int                 cycle_count = 0;

   modular_exponentiation dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A modulus of zero stands for 2^WIDTH, where the product just wraps.
   function automatic logic [63:0] mul_reduce(logic [63:0] a, logic [63:0] b,
                                              logic [WIDTH-1:0] m);
      logic [63:0] product;
      product = a * b;
      if (m == '0) begin
         return {{(64-WIDTH){1'b0}}, product[WIDTH-1:0]};
      end
      return product % {{(64-WIDTH){1'b0}}, m};
   endfunction

   function automatic logic [WIDTH-1:0] predict_power(logic opcode, logic [WIDTH-1:0] base,
                                                      logic [WIDTH-1:0] exponent,
                                                      logic [WIDTH-1:0] m);
      logic [WIDTH-1:0] e;
      logic [63:0]      acc;
      logic [63:0]      b;
      if (opcode == OPC_INVERSE) begin
         // Fermat's rule needs modulus-2 of at least one; zero counts as negative.
         if (m < 3) begin
            return 1;
         end
         e = m - 2;
      end else begin
         e = exponent;
      end
      if (e == '0) begin
         return 1;
      end
      acc = 64'd1;
      b = {{(64-WIDTH){1'b0}}, base};
      if (m != '0) begin
         b = b % {{(64-WIDTH){1'b0}}, m};
         acc = acc % {{(64-WIDTH){1'b0}}, m};
      end
      for (int i = 0; i < WIDTH; i++) begin
         if (e[i]) begin
            acc = mul_reduce(acc, b, m);
         end
         b = mul_reduce(b, b, m);
      end
      return acc[WIDTH-1:0];
   endfunction

   function automatic void queue_request(logic opcode, logic [WIDTH-1:0] base,
                                         logic [WIDTH-1:0] exponent);
      power_request_type r;
      r.opcode = opcode;
      r.base = base;
      r.exponent = exponent;
      pending_requests.insert(pending_requests.size(), r);
   endfunction

   // Most exponents are short to keep the run brief; a quarter use all bits.
   function automatic void queue_random_request();
      logic             opcode;
      logic [WIDTH-1:0] base;
      logic [WIDTH-1:0] exponent;
      opcode = ($urandom_range(3) == 0) ? OPC_INVERSE : OPC_POWER;
      case ($urandom_range(7))
         0: base = '0;
         1: base = '1;
         2: base = WIDTH'($urandom_range(16));
         default: base = $urandom;
      endcase
      case ($urandom_range(7))
         0: exponent = '0;
         1, 2: exponent = $urandom;
         default: exponent = $urandom >> $urandom_range(31, 16);
      endcase
      queue_request(opcode, base, exponent);
   endfunction

   task automatic wait_for_idle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_results.size() != 0);
   endtask

   task automatic write_modulus(input logic [WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      modulus_now = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sender side: a new item goes out once the previous one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_fired) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_request = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {next_request.exponent, next_request.base};
               req_tuser <= next_request.opcode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            expected_results.insert(expected_results.size(),
                                    predict_power(req_tuser, req_tdata[WIDTH-1:0],
                                                  req_tdata[2*WIDTH-1:WIDTH],
                                                  modulus_now));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result: expected none, actual %0h", rsp_tdata);
               error_count++;
            end else begin
               wanted_result = expected_results.pop_front();
               if (rsp_tdata !== wanted_result) begin
                  $error("result: expected %0h, actual %0h", wanted_result, rsp_tdata);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [WIDTH-1:0] phase_modulus [NUM_PHASES];
      phase_modulus[0] = '1;
      phase_modulus[1] = 1;
      phase_modulus[2] = 2;
      phase_modulus[3] = 3;
      phase_modulus[4] = '0;
      phase_modulus[5] = 65521;
      phase_modulus[6] = $urandom | 32'h8000_0001;
      phase_modulus[7] = MODULUS_RESET;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Under the reset modulus: zero power, plain powers, reduction of the
      // base, and inverses of invertible and non-invertible values.
      queue_request(OPC_POWER, 0, 0);
      queue_request(OPC_POWER, 2, 10);
      queue_request(OPC_POWER, 0, 5);
      queue_request(OPC_POWER, MODULUS_RESET + 1, 1);
      queue_request(OPC_POWER, 12345, 32'h8000_0000);
      queue_request(OPC_INVERSE, 2, '1);
      queue_request(OPC_INVERSE, 0, 0);
      queue_request(OPC_INVERSE, MODULUS_RESET, 7);
      wait_for_idle();

      for (int k = 0; k < NUM_PHASES; k++) begin
         write_modulus(phase_modulus[k]);
         case (k % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 49;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 49;
            end
            default: begin
               send_idle_pct = 7;
               recv_stall_pct = 7;
            end
         endcase
         queue_request(OPC_POWER, '1, 0);
         queue_request(OPC_POWER, '1, '1);
         queue_request(OPC_INVERSE, '1, $urandom);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // In one phase the sender holds off until every result is back.
            if (k == 1 && n == RANDOM_PER_PHASE / 2) begin
               wait_for_idle();
            end
            queue_random_request();
         end
         wait_for_idle();
      end

      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/mexp_pkg.sv
design/mexp_sequencer.sv
design/mexp_datapath.sv
design/modular_exponentiation.sv
test/tb.sv
